// ===== hdl/mrnp_pkg.sv =====
// Shared types and constants for the multi-radix number parser.
// No dependencies; imported by mrnp_step and multi_radix_number_parser_core.
package mrnp_pkg;

    // Parser modes
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_SKIP = 3'd1,
        MODE_ZERO = 3'd2,
        MODE_HEX  = 3'd3,
        MODE_OCT  = 3'd4,
        MODE_BIN  = 3'd5,
        MODE_DEC  = 3'd6
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    localparam logic [31:0] C_DEC_LIMIT = 32'd429496729;
    localparam logic [31:0] C_OVF_VALUE = 32'h00ff_ffff;
    localparam logic [31:0] C_HEX_MASK  = 32'hf000_0000;
    localparam logic [31:0] C_OCT_MASK  = 32'he000_0000;
    localparam logic [31:0] C_BIN_MASK  = 32'h8000_0000;

    // Next state and result of one character, from the step logic to the core
    typedef struct packed {
        t_mode       mode;
        logic [31:0] acc;
        logic        have_digit;
        logic        emit;
        logic [31:0] value;
        t_status     status;
        logic        off_pos;   // offset is the current position, else zero
    } t_step;

endpackage

// ===== hdl/multi_radix_number_parser_core.sv =====
// Top level of the multi-radix number parser: parser state, position
// counter and output register. Uses mrnp_pkg and mrnp_step.
//
//  channel  dir  tdata (low bit up)                tuser         tlast
//  s_axis   in   ch[7:0]                           start_req     -
//  m_axis   out  value[31:0], stop_offset[15:0]    status[1:0]   -
//
// One character per cycle: each transfer updates the state through one
// level of decode and a shift-add, and a result appears in the output
// register the cycle after the terminating character.
// A stalled output holds the result; the input keeps taking characters
// while the output register is empty or being drained in the same cycle.
// Synchronous active-low reset returns the parser to idle.
module multi_radix_number_parser_core #(
    parameter int POS_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // ch
    input  logic        i_s_axis_tuser,   // start_req
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // value[31:0], stop_offset[47:32]
    output logic [1:0]  o_m_axis_tuser    // status
);
    import mrnp_pkg::*;

    localparam logic [POS_WIDTH-1:0] PosMax = '1;

    t_mode                r_mode, n_mode;
    logic [31:0]          r_acc, n_acc;
    logic                 r_have_digit, n_have_digit;
    logic [POS_WIDTH-1:0] r_pos, n_pos;
    logic                 r_out_valid, n_out_valid;
    logic [31:0]          r_out_value, n_out_value;
    logic [15:0]          r_out_offset, n_out_offset;
    t_status              r_out_status, n_out_status;

    t_step                step;
    logic                 in_xfer;
    logic [POS_WIDTH-1:0] pos_eff;
    logic [31:0]          pos_ext;
    logic [15:0]          pos_sat;

    mrnp_step u_step (
        .i_mode       (r_mode),
        .i_acc        (r_acc),
        .i_have_digit (r_have_digit),
        .i_start      (i_s_axis_tuser),
        .i_ch         (i_s_axis_tdata),
        .o_step       (step)
    );

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    // Position of the current byte, saturated to the offset width
    always_comb begin
        pos_eff = i_s_axis_tuser ? '0 : r_pos;
        pos_ext = 32'(pos_eff);
        pos_sat = (|pos_ext[31:16]) ? 16'hffff : pos_ext[15:0];
    end

    // Next state and output register
    always_comb begin
        n_mode       = r_mode;
        n_acc        = r_acc;
        n_have_digit = r_have_digit;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_value  = r_out_value;
        n_out_offset = r_out_offset;
        n_out_status = r_out_status;
        if (in_xfer) begin
            n_mode       = step.mode;
            n_acc        = step.acc;
            n_have_digit = step.have_digit;
            n_pos        = pos_eff;
            if (step.mode != MODE_IDLE && pos_eff != PosMax) begin
                n_pos = pos_eff + 1'b1;
            end
            if (step.emit) begin
                n_out_valid  = 1'b1;
                n_out_value  = step.value;
                n_out_status = step.status;
                n_out_offset = step.off_pos ? pos_sat : 16'd0;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_acc        <= 32'd0;
            r_have_digit <= 1'b0;
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_acc        <= n_acc;
            r_have_digit <= n_have_digit;
            r_pos        <= n_pos;
            r_out_valid  <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_offset <= n_out_offset;
        r_out_status <= n_out_status;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_offset, r_out_value};
    assign o_m_axis_tuser  = r_out_status;

endmodule

// ===== hdl/mrnp_step.sv =====
// Combinational update of the parser for one character: prefix and radix
// selection, digit decode, overflow check and accumulate. Uses mrnp_pkg.
module mrnp_step (
    input  mrnp_pkg::t_mode i_mode,
    input  logic [31:0]     i_acc,
    input  logic            i_have_digit,
    input  logic            i_start,
    input  logic [7:0]      i_ch,
    output mrnp_pkg::t_step o_step
);
    import mrnp_pkg::*;

    t_mode       mode_eff;
    logic [31:0] acc_eff;
    logic        hd_eff;
    t_mode       dmode;
    logic        dvalid;
    logic [3:0]  dval;
    logic        ovf;
    logic [31:0] acc_new;
    t_step       dstep;

    // A start flag restarts the string with this byte
    always_comb begin
        mode_eff = i_start ? MODE_SKIP : i_mode;
        acc_eff  = (i_start || mode_eff == MODE_SKIP) ? 32'd0 : i_acc;
        hd_eff   = (i_start || mode_eff == MODE_SKIP) ? 1'b0 : i_have_digit;
    end

    // Radix used if this byte goes through the digit path
    always_comb begin
        case (mode_eff)
            MODE_SKIP: dmode = MODE_DEC;
            MODE_ZERO: dmode = MODE_OCT;
            default:   dmode = mode_eff;
        endcase
    end

    // Digit decode
    always_comb begin
        dvalid = 1'b0;
        dval   = 4'd0;
        if (i_ch inside {["0":"9"]}) begin
            dval   = 4'(i_ch - 8'h30);
            dvalid = (dmode == MODE_HEX) || (dmode == MODE_DEC) ||
                     (dmode == MODE_OCT && i_ch <= "7") ||
                     (dmode == MODE_BIN && i_ch <= "1");
        end else if (dmode == MODE_HEX && (i_ch inside {["A":"F"]})) begin
            dval   = 4'(i_ch - 8'h37);
            dvalid = 1'b1;
        end else if (dmode == MODE_HEX && (i_ch inside {["a":"f"]})) begin
            dval   = 4'(i_ch - 8'h57);
            dvalid = 1'b1;
        end
    end

    // Overflow check and accumulate
    always_comb begin
        case (dmode)
            MODE_HEX: begin
                ovf     = |(acc_eff & C_HEX_MASK);
                acc_new = {acc_eff[27:0], 4'd0} + {28'd0, dval};
            end
            MODE_OCT: begin
                ovf     = |(acc_eff & C_OCT_MASK);
                acc_new = {acc_eff[28:0], 3'd0} + {28'd0, dval};
            end
            MODE_BIN: begin
                ovf     = |(acc_eff & C_BIN_MASK);
                acc_new = {acc_eff[30:0], dval[0]};
            end
            default: begin
                ovf     = (acc_eff > C_DEC_LIMIT) ||
                          (acc_eff == C_DEC_LIMIT && dval > 4'd5);
                acc_new = {acc_eff[28:0], 3'd0} + {acc_eff[30:0], 1'b0} + {28'd0, dval};
            end
        endcase
    end

    // Outcome of the digit path
    always_comb begin
        dstep.mode       = dmode;
        dstep.acc        = acc_eff;
        dstep.have_digit = hd_eff;
        dstep.emit       = 1'b0;
        dstep.value      = 32'd0;
        dstep.status     = ST_OK;
        dstep.off_pos    = 1'b0;
        if (!dvalid) begin
            dstep.mode    = MODE_IDLE;
            dstep.emit    = 1'b1;
            dstep.value   = hd_eff ? acc_eff : 32'd0;
            dstep.status  = hd_eff ? ST_OK : ST_NONE;
            dstep.off_pos = hd_eff;
        end else if (ovf) begin
            dstep.mode   = MODE_IDLE;
            dstep.emit   = 1'b1;
            dstep.value  = C_OVF_VALUE;
            dstep.status = ST_OVF;
        end else begin
            dstep.acc        = acc_new;
            dstep.have_digit = 1'b1;
        end
    end

    // Mode dispatch
    always_comb begin
        o_step.mode       = mode_eff;
        o_step.acc        = acc_eff;
        o_step.have_digit = hd_eff;
        o_step.emit       = 1'b0;
        o_step.value      = 32'd0;
        o_step.status     = ST_OK;
        o_step.off_pos    = 1'b0;
        case (mode_eff)
            MODE_SKIP: begin
                if (i_ch inside {[8'd1:8'd32]}) begin
                    o_step.mode = MODE_SKIP;
                end else if (i_ch == "0") begin
                    o_step.mode = MODE_ZERO;
                end else if (i_ch == "b" || i_ch == "B") begin
                    o_step.mode = MODE_BIN;
                end else begin
                    o_step = dstep;
                end
            end
            MODE_ZERO: begin
                if (i_ch == "x" || i_ch == "X") begin
                    o_step.mode = MODE_HEX;
                end else if (i_ch inside {["0":"7"]}) begin
                    o_step = dstep;
                end else begin
                    o_step.mode    = MODE_IDLE;
                    o_step.emit    = 1'b1;
                    o_step.off_pos = 1'b1;
                end
            end
            MODE_HEX, MODE_OCT, MODE_BIN, MODE_DEC: begin
                o_step = dstep;
            end
            default: begin
                o_step.mode = MODE_IDLE;
            end
        endcase
    end

endmodule
